@@ hdl/ftpst_pkg.sv @@
// Package for the FTP reply parser with AUTH TLS upgrade.
// Holds the phase codes, action codes, byte constants and shared structs.
// No dependencies.
`default_nettype none

package ftpst_pkg;

	localparam int ByteW  = 8;
	localparam int CodeW  = 10;
	localparam int PhaseW = 4;
	localparam int ActW   = 2;

	localparam logic [PhaseW-1:0] PH_GREET   = 4'd0;
	localparam logic [PhaseW-1:0] PH_ANSWER  = 4'd6;
	localparam logic [PhaseW-1:0] PH_ANS_END = 4'd11;
	localparam logic [PhaseW-1:0] PH_CLOSED  = 4'd12;
	localparam logic [PhaseW-1:0] PH_HANDOFF = 4'd13;

	localparam logic [PhaseW-1:0] OFF_DIGIT1 = 4'd1;
	localparam logic [PhaseW-1:0] OFF_DIGIT2 = 4'd2;
	localparam logic [PhaseW-1:0] OFF_DIGIT3 = 4'd3;
	localparam logic [PhaseW-1:0] OFF_SEP    = 4'd4;
	localparam logic [PhaseW-1:0] OFF_TEXT   = 4'd5;

	localparam logic [ActW-1:0] ACT_NONE  = 2'd0;
	localparam logic [ActW-1:0] ACT_AUTH  = 2'd1;
	localparam logic [ActW-1:0] ACT_TLS   = 2'd2;
	localparam logic [ActW-1:0] ACT_CLOSE = 2'd3;

	localparam logic [CodeW-1:0] CODE_TLS_OK = 10'd234;

	localparam logic [ByteW-1:0] CH_ZERO   = 8'h30;
	localparam logic [ByteW-1:0] CH_NINE   = 8'h39;
	localparam logic [ByteW-1:0] CH_SPACE  = 8'h20;
	localparam logic [ByteW-1:0] CH_HYPHEN = 8'h2D;
	localparam logic [ByteW-1:0] CH_TILDE  = 8'h7E;
	localparam logic [ByteW-1:0] CH_CR     = 8'h0D;
	localparam logic [ByteW-1:0] CH_LF     = 8'h0A;

	typedef struct packed {
		logic [PhaseW-1:0] phase;
		logic [CodeW-1:0]  accum;
		logic              final_line;
	} parse_state_t;

	typedef struct packed {
		logic             banner_valid;
		logic [ByteW-1:0] banner_byte;
		logic [ActW-1:0]  action;
		logic [CodeW-1:0] reply_code;
		logic             segment_done;
	} result_t;

endpackage

`default_nettype wire

@@ hdl/ftpst_step.sv @@
// Combinational parser step: one byte against the current parser state.
// Produces the next parser state and the result item. Depends on ftpst_pkg.
`default_nettype none

module ftpst_step import ftpst_pkg::*; (
	input  wire parse_state_t     cur,
	input  wire logic [ByteW-1:0] rx_byte,
	input  wire logic             end_of_segment,
	output parse_state_t          nxt,
	output result_t               res
);

	logic              is_start;
	logic              is_answer;
	logic [PhaseW-1:0] eff;
	logic [PhaseW-1:0] off;
	logic [CodeW-1:0]  acc0;
	logic [CodeW-1:0]  acc_mul;
	logic [CodeW-1:0]  digit;
	logic              is_digit;
	logic              is_print;
	logic              echo;
	logic [ActW-1:0]   act;

	always_comb begin
		is_start  = (cur.phase == PH_GREET) || (cur.phase == PH_ANSWER);
		is_answer = (cur.phase >= PH_ANSWER) && (cur.phase <= PH_ANS_END);
		eff       = is_start ? cur.phase + 4'd1 : cur.phase;
		off       = is_answer ? eff - PH_ANSWER : eff;
		if (cur.phase > PH_ANS_END) begin
			off = '0;
		end
		acc0      = is_start ? '0 : cur.accum;
		acc_mul   = {acc0[CodeW-4:0], 3'b000} + {acc0[CodeW-2:0], 1'b0};
		digit     = {{(CodeW-ByteW){1'b0}}, rx_byte - CH_ZERO};
		is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
		is_print  = (rx_byte >= CH_SPACE) && (rx_byte <= CH_TILDE);

		nxt       = cur;
		nxt.accum = acc0;
		echo      = 1'b0;
		act       = ACT_NONE;

		case (off)
			OFF_DIGIT1, OFF_DIGIT2, OFF_DIGIT3: begin
				if (is_digit) begin
					nxt.accum = acc_mul + digit;
					nxt.phase = eff + 4'd1;
					echo      = 1'b1;
				end else begin
					nxt.phase = PH_CLOSED;
					act       = ACT_CLOSE;
				end
			end
			OFF_SEP: begin
				if ((rx_byte == CH_SPACE) || (rx_byte == CH_HYPHEN)) begin
					nxt.final_line = (rx_byte == CH_SPACE);
					nxt.phase      = eff + 4'd1;
					echo           = 1'b1;
				end else begin
					nxt.phase = PH_CLOSED;
					act       = ACT_CLOSE;
				end
			end
			OFF_TEXT: begin
				if (rx_byte == CH_CR) begin
					echo = 1'b0;
				end else if (rx_byte == CH_LF) begin
					if (!is_answer) begin
						echo = 1'b1;
						if (cur.final_line) begin
							act       = ACT_AUTH;
							nxt.phase = PH_ANSWER;
						end else begin
							nxt.phase = PH_GREET;
						end
					end else if (acc0 == CODE_TLS_OK) begin
						act       = ACT_TLS;
						nxt.phase = PH_HANDOFF;
						nxt.accum = '0;
					end else begin
						act       = ACT_CLOSE;
						nxt.phase = PH_CLOSED;
					end
				end else if (!is_print) begin
					act       = ACT_CLOSE;
					nxt.phase = PH_CLOSED;
				end else begin
					echo = 1'b1;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase

		res.banner_valid = echo;
		res.banner_byte  = echo ? rx_byte : '0;
		res.action       = act;
		res.reply_code   = nxt.accum;
		res.segment_done = end_of_segment;
	end

endmodule

`default_nettype wire

@@ hdl/ftpst_out_stage.sv @@
// Result register with its valid/stall handshake toward the consumer.
// Loads a new result item whenever it is empty or being drained. Depends on ftpst_pkg.
`default_nettype none

module ftpst_out_stage import ftpst_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t res_in,
	output logic         advance,
	output logic         out_valid,
	input  wire logic    out_stall,
	output result_t      res_out
);

	logic    valid_s2;
	result_t res_s2;

	assign advance   = !valid_s2 || !out_stall;
	assign out_valid = valid_s2;
	assign res_out   = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load) begin
			res_s2 <= res_in;
		end
	end

endmodule

`default_nettype wire

@@ hdl/ftp_reply_starttls_parser_core.sv @@
// Top level of the FTP reply parser with AUTH TLS upgrade.
// Holds the input register and parser state; uses ftpst_step, ftpst_out_stage, ftpst_pkg.
//
// The block takes one server reply byte per item and returns exactly one result item
// per byte, in order. An item passes from the input register into the result register,
// and a new item is accepted every cycle while the consumer keeps stall low. The
// parser state advances when an item moves from the input register into the result
// register.
`default_nettype none

module ftp_reply_starttls_parser_core import ftpst_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [ByteW-1:0] rx_byte,
	input  wire logic             end_of_segment,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  banner_valid,
	output logic [ByteW-1:0]      banner_byte,
	output logic [ActW-1:0]       action,
	output logic [CodeW-1:0]      reply_code,
	output logic                  segment_done
);

	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             eos_s1;
	logic             advance;
	logic             in_accept;
	parse_state_t     state_q;
	parse_state_t     state_nxt;
	result_t          res_new;
	result_t          res_out;

	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= rx_byte;
			eos_s1  <= end_of_segment;
		end
	end

	ftpst_step u_step (
		.cur            (state_q),
		.rx_byte        (byte_s1),
		.end_of_segment (eos_s1),
		.nxt            (state_nxt),
		.res            (res_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= PH_GREET;
			state_q.accum      <= '0;
			state_q.final_line <= 1'b0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	ftpst_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.res_in    (res_new),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_out   (res_out)
	);

	assign banner_valid = res_out.banner_valid;
	assign banner_byte  = res_out.banner_byte;
	assign action       = res_out.action;
	assign reply_code   = res_out.reply_code;
	assign segment_done = res_out.segment_done;

	a_closed_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_CLOSED) |=> (state_q.phase == PH_CLOSED))
		else $error("Parser left the closed phase.");

	a_handoff_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_HANDOFF) |=> (state_q.phase == PH_HANDOFF))
		else $error("Parser left the handoff phase.");

	a_tls_clears_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && action == ACT_TLS) |-> (reply_code == '0))
		else $error("Handoff item carries a nonzero reply code.");

	a_no_echo_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && banner_valid) |-> (action != ACT_CLOSE && action != ACT_TLS))
		else $error("Echoed byte on a close or handoff item.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && valid_s1))
		else $error("Input stalled while the pipeline could move.");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for ftp_reply_starttls_parser_core: drives a server reply byte stream and checks
// every result item against a directed table or a behavioral parser held in this file.
// Depends on ftpst_pkg and the RTL under hdl/.
`default_nettype none

module tb_top import ftpst_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ItemTarget  = 1950;
	localparam int CycleLimit  = 1000000;
	localparam int HoldCycles  = 150;
	localparam int HoldAfter   = 400;
	localparam int DrainWindow = 8;

	typedef struct packed {
		logic [ByteW-1:0] b;
		logic             eos;
		logic             typed;
		result_t          want;
	} stim_t;

	typedef enum int {
		END_BAD_GREETING,
		END_TLS,
		END_TLS_MULTI,
		END_OTHER_CODE,
		END_BAD_ANSWER
	} ending_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [ByteW-1:0] rx_byte;
	logic             end_of_segment;
	logic             out_valid;
	logic             out_stall;
	logic             banner_valid;
	logic [ByteW-1:0] banner_byte;
	logic [ActW-1:0]  action;
	logic [CodeW-1:0] reply_code;
	logic             segment_done;

	logic [PhaseW-1:0] reply_phase;
	logic [CodeW-1:0]  reply_acc;
	logic              last_line;

	stim_t   stim_q[$];
	result_t pending[$];
	int      mismatches;
	int      results_seen;
	int      parsed_items;
	int      n_auth;
	int      n_tls;
	int      n_close;
	int      tx_quiet;
	int      rx_quiet;
	int      cycles;

	stim_t dir_rows [0:20] = '{
		'{CH_ZERO,   1'b0, 1'b1, '{1'b1, CH_ZERO,   ACT_NONE, 10'd0,   1'b0}},
		'{CH_ZERO,   1'b1, 1'b1, '{1'b1, CH_ZERO,   ACT_NONE, 10'd0,   1'b1}},
		'{CH_NINE,   1'b0, 1'b1, '{1'b1, CH_NINE,   ACT_NONE, 10'd9,   1'b0}},
		'{CH_HYPHEN, 1'b1, 1'b1, '{1'b1, CH_HYPHEN, ACT_NONE, 10'd9,   1'b1}},
		'{CH_SPACE,  1'b0, 1'b1, '{1'b1, CH_SPACE,  ACT_NONE, 10'd9,   1'b0}},
		'{CH_TILDE,  1'b0, 1'b1, '{1'b1, CH_TILDE,  ACT_NONE, 10'd9,   1'b0}},
		'{CH_CR,     1'b1, 1'b1, '{1'b0, 8'h00,     ACT_NONE, 10'd9,   1'b1}},
		'{CH_LF,     1'b0, 1'b1, '{1'b1, CH_LF,     ACT_NONE, 10'd9,   1'b0}},
		'{CH_NINE,   1'b0, 1'b1, '{1'b1, CH_NINE,   ACT_NONE, 10'd9,   1'b0}},
		'{CH_NINE,   1'b0, 1'b1, '{1'b1, CH_NINE,   ACT_NONE, 10'd99,  1'b0}},
		'{CH_NINE,   1'b0, 1'b1, '{1'b1, CH_NINE,   ACT_NONE, 10'd999, 1'b0}},
		'{CH_HYPHEN, 1'b0, 1'b1, '{1'b1, CH_HYPHEN, ACT_NONE, 10'd999, 1'b0}},
		'{CH_LF,     1'b0, 1'b1, '{1'b1, CH_LF,     ACT_NONE, 10'd999, 1'b0}},
		'{8'h32,     1'b0, 1'b1, '{1'b1, 8'h32,     ACT_NONE, 10'd2,   1'b0}},
		'{8'h32,     1'b1, 1'b0, '0},
		'{CH_ZERO,   1'b0, 1'b0, '0},
		'{CH_HYPHEN, 1'b0, 1'b0, '0},
		'{8'h41,     1'b1, 1'b0, '0},
		'{CH_CR,     1'b0, 1'b0, '0},
		'{CH_CR,     1'b0, 1'b0, '0},
		'{CH_LF,     1'b1, 1'b0, '0}
	};

	ftp_reply_starttls_parser_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.end_of_segment (end_of_segment),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.banner_valid   (banner_valid),
		.banner_byte    (banner_byte),
		.action         (action),
		.reply_code     (reply_code),
		.segment_done   (segment_done)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic result_t parse_reply_byte(input logic [ByteW-1:0] b, input logic eos);
		result_t           r;
		logic [PhaseW-1:0] base;
		logic [PhaseW-1:0] off;
		logic              live;
		logic              echo;
		r = '0;
		r.action = ACT_NONE;
		echo = 1'b0;
		live = 1'b1;
		base = PH_GREET;
		off = '0;
		if (reply_phase <= PH_GREET + OFF_TEXT) begin
			off = reply_phase;
		end else if (reply_phase <= PH_ANS_END) begin
			base = PH_ANSWER;
			off = reply_phase - PH_ANSWER;
		end else begin
			live = 1'b0;
		end
		if (live && off == '0) begin
			reply_acc = '0;
			off = OFF_DIGIT1;
		end
		if (live) begin
			case (off)
				OFF_DIGIT1, OFF_DIGIT2, OFF_DIGIT3: begin
					if (b >= CH_ZERO && b <= CH_NINE) begin
						reply_acc = CodeW'(reply_acc * 10 + (b - CH_ZERO));
						reply_phase = base + off + 4'd1;
						echo = 1'b1;
					end else begin
						reply_phase = PH_CLOSED;
						r.action = ACT_CLOSE;
					end
				end
				OFF_SEP: begin
					if (b == CH_SPACE || b == CH_HYPHEN) begin
						last_line = (b == CH_SPACE);
						reply_phase = base + OFF_TEXT;
						echo = 1'b1;
					end else begin
						reply_phase = PH_CLOSED;
						r.action = ACT_CLOSE;
					end
				end
				OFF_TEXT: begin
					if (b == CH_CR) begin
						echo = 1'b0;
					end else if (b == CH_LF) begin
						if (base == PH_GREET) begin
							echo = 1'b1;
							if (last_line) begin
								r.action = ACT_AUTH;
								reply_phase = PH_ANSWER;
							end else begin
								reply_phase = PH_GREET;
							end
						end else if (reply_acc == CODE_TLS_OK) begin
							r.action = ACT_TLS;
							reply_phase = PH_HANDOFF;
							reply_acc = '0;
						end else begin
							r.action = ACT_CLOSE;
							reply_phase = PH_CLOSED;
						end
					end else if (b < CH_SPACE || b > CH_TILDE) begin
						r.action = ACT_CLOSE;
						reply_phase = PH_CLOSED;
					end else begin
						echo = 1'b1;
					end
				end
				default: begin
					echo = 1'b0;
				end
			endcase
		end
		r.banner_valid = echo;
		r.banner_byte = echo ? b : '0;
		r.reply_code = reply_acc;
		r.segment_done = eos;
		return r;
	endfunction

	function automatic int next_gap(inout int quiet_left);
		int r;
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			quiet_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [ByteW-1:0] non_digit();
		logic [ByteW-1:0] b;
		do b = 8'($urandom_range(0, 255)); while (b >= CH_ZERO && b <= CH_NINE);
		return b;
	endfunction

	function automatic logic [ByteW-1:0] non_separator();
		logic [ByteW-1:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == CH_SPACE || b == CH_HYPHEN);
		return b;
	endfunction

	function automatic logic [ByteW-1:0] non_text();
		logic [ByteW-1:0] b;
		do b = 8'($urandom_range(0, 255));
		while ((b >= CH_SPACE && b <= CH_TILDE) || b == CH_CR || b == CH_LF);
		return b;
	endfunction

	function automatic int text_length();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(0, 16);
	endfunction

	task automatic push_byte(input logic [ByteW-1:0] b);
		stim_t s;
		s = '0;
		s.b = b;
		s.eos = ($urandom_range(0, 3) == 0);
		stim_q.push_back(s);
	endtask

	task automatic push_digits(input int code, input int count);
		int digs [3];
		digs[0] = code / 100;
		digs[1] = (code / 10) % 10;
		digs[2] = code % 10;
		for (int i = 0; i < count; i++)
			push_byte(CH_ZERO + 8'(digs[i]));
	endtask

	task automatic push_text(input int len);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				push_byte(CH_CR);
			else
				push_byte(8'($urandom_range(CH_SPACE, CH_TILDE)));
		end
	endtask

	task automatic push_line(input logic [ByteW-1:0] sep, input int code);
		push_digits(code, 3);
		push_byte(sep);
		push_text(text_length());
		if ($urandom_range(0, 1) == 1)
			push_byte(CH_CR);
		push_byte(CH_LF);
	endtask

	task automatic push_broken_line();
		int spot;
		spot = $urandom_range(0, 4);
		push_digits($urandom_range(0, 999), (spot < 3) ? spot : 3);
		if (spot < 3) begin
			push_byte(non_digit());
		end else if (spot == 3) begin
			push_byte(non_separator());
		end else begin
			push_byte(($urandom_range(0, 1) == 1) ? CH_SPACE : CH_HYPHEN);
			push_text($urandom_range(0, 10));
			push_byte(non_text());
		end
	endtask

	task automatic build_stimulus();
		ending_t ending;
		int      code;
		foreach (dir_rows[i])
			stim_q.push_back(dir_rows[i]);
		while (stim_q.size() < ItemTarget - 60)
			push_line(CH_HYPHEN, $urandom_range(0, 999));
		ending = ending_t'($urandom_range(0, 4));
		if (ending == END_BAD_GREETING) begin
			push_broken_line();
		end else begin
			push_line(CH_SPACE, $urandom_range(0, 999));
			case (ending)
				END_TLS: push_line(CH_SPACE, CODE_TLS_OK);
				END_TLS_MULTI: begin
					push_line(CH_HYPHEN, CODE_TLS_OK);
					push_line(CH_SPACE, CODE_TLS_OK);
				end
				END_OTHER_CODE: begin
					do code = $urandom_range(0, 999); while (code == CODE_TLS_OK);
					push_line(($urandom_range(0, 1) == 1) ? CH_SPACE : CH_HYPHEN, code);
				end
				default: push_broken_line();
			endcase
		end
		push_byte(8'hFF);
		push_byte(8'h00);
		for (int i = 0; i < 30; i++)
			push_byte(8'($urandom_range(0, 255)));
	endtask

	function automatic void compare_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
		end
	endfunction

	initial begin
		int      gap;
		int      drain_at;
		stim_t   s;
		result_t r;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		end_of_segment = 1'b0;
		reply_phase = PH_GREET;
		reply_acc = '0;
		last_line = 1'b0;
		build_stimulus();
		drain_at = stim_q.size() / 2;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int idx = 0; idx < stim_q.size(); idx++) begin
			s = stim_q[idx];
			@(negedge clk);
			gap = next_gap(tx_quiet);
			if (idx == drain_at) begin
				in_valid <= 1'b0;
				do @(negedge clk); while (pending.size() != 0);
			end else if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			in_valid <= 1'b1;
			rx_byte <= s.b;
			end_of_segment <= s.eos;
			do @(posedge clk); while (in_stall);
			if (reply_phase < PH_CLOSED)
				parsed_items++;
			r = parse_reply_byte(s.b, s.eos);
			case (r.action)
				ACT_AUTH: n_auth++;
				ACT_TLS: n_tls++;
				ACT_CLOSE: n_close++;
				default: ;
			endcase
			pending.push_back(s.typed ? s.want : r);
		end
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending.size() != 0) @(negedge clk);
		repeat (DrainWindow) @(negedge clk);
		$display("Sent %0d bytes, %0d of them parsed before the stream was closed or handed off.",
			stim_q.size(), parsed_items);
		$display("Checked %0d results; AUTH requests %0d, TLS handoffs %0d, closes %0d.",
			results_seen, n_auth, n_tls, n_close);
		if (mismatches == 0)
			$display("ftp_reply_starttls_parser_core verification clean");
		else
			$display("ftp_reply_starttls_parser_core verification failed");
		$finish;
	end

	initial begin
		int stall_left;
		bit hold_done;
		out_stall = 1'b0;
		stall_left = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && results_seen >= HoldAfter) begin
				hold_done = 1'b1;
				stall_left = HoldCycles - 1;
				out_stall <= 1'b1;
			end else begin
				stall_left = next_gap(rx_quiet);
				out_stall <= (stall_left != 0);
				if (stall_left != 0)
					stall_left--;
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				$display("%0t ns: result item with none expected, byte %0d action %0d code %0d",
					$time, banner_byte, action, reply_code);
			end else begin
				want = pending.pop_front();
				compare_field("banner_valid", want.banner_valid, banner_valid);
				compare_field("banner_byte", want.banner_byte, banner_byte);
				compare_field("action", want.action, action);
				compare_field("reply_code", want.reply_code, reply_code);
				compare_field("segment_done", want.segment_done, segment_done);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CycleLimit) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycles, pending.size());
			$display("ftp_reply_starttls_parser_core verification failed");
			$finish;
		end
	end

endmodule

`default_nettype wire
